FILE: sv/pnsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsf_pkg
// Shared types, constants and mask helpers for the packed nibble span fill.
// ----------------------------------------------------------------------------
package pnsf_pkg;

    localparam int FRAME_WORDS = 2048;
    localparam int AW          = $clog2(FRAME_WORDS);

    typedef enum logic [1:0] {
        REQ_FILL_CLIP   = 2'd0,
        REQ_FILL_NOCLIP = 2'd1,
        REQ_READ        = 2'd2,
        REQ_NONE        = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_CLIPPED  = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_REVERSED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_ADDR,
        S_CHECK,
        S_FILL,
        S_DRAIN,
        S_RDWAIT
    } t_state;

    localparam logic [2:0] CFG_ROW_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_CLIP_LEFT   = 3'd1;
    localparam logic [2:0] CFG_CLIP_RIGHT  = 3'd2;
    localparam logic [2:0] CFG_CLIP_TOP    = 3'd3;
    localparam logic [2:0] CFG_CLIP_BOTTOM = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] row;
        logic signed [15:0] x_left;
        logic signed [15:0] x_right;
        logic [31:0]        pattern;
        logic [10:0]        read_index;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
    } t_out;

    // nibbles below the first painted pixel
    function automatic logic [31:0] keep_low(input logic [2:0] n);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < n) begin
                m[4*i +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

    // nibbles above the last painted pixel
    function automatic logic [31:0] keep_high(input logic [2:0] n);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) > n) begin
                m[4*i +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

endpackage

FILE: sv/pnsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pnsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/packed_nibble_span_fill_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_nibble_span_fill_core
// Span fill and word read on a 4-bit packed framebuffer held in one RAM.
// Sequence: a fill runs SETUP, ADDR, CHECK, FILL per word painted, DRAIN;
// a fill outside memory skips FILL; a reversed or clipped fill, an unused
// request type or an out-of-range read goes to DRAIN, other reads via RDWAIT.
// One request at a time. Throughput: one word per cycle through the RAM
// read-modify-write loop; a 128-pixel row covers up to 17 words.
// Reset: the RAM is cleared one word a cycle, all 2048 words, before the
// first beat is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module packed_nibble_span_fill_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  pnsf_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output pnsf_pkg::t_out   o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [14:0]      i_cfg_data
);
    import pnsf_pkg::*;

    t_state  r_state, n_state;
    t_in     r_in;
    t_status r_st;
    logic    r_ovalid;
    t_out    r_out;
    logic [31:0] r_data;

    logic [14:0] r_row_width;
    logic [13:0] r_clip_left, r_clip_right, r_clip_top, r_clip_bottom;

    logic signed [16:0] r_xl, r_xr;
    logic signed [31:0] r_base, r_loff, r_roff;
    logic [AW-1:0] r_lw, r_rw, r_w, r_wa, r_clr;
    logic [31:0]   r_ml, r_mr;
    logic          r_wv;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata, keep;

    logic signed [16:0] row17, xl17, xr17, cl17, cr17, ct17, cb17;
    logic signed [16:0] xl_c, xr_c;
    logic               rd_ok, outside, out_free;

    pnsf_ram #(
        .WIDTH (32),
        .DEPTH (FRAME_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign row17 = 17'(r_in.row);
    assign xl17  = 17'(r_in.x_left);
    assign xr17  = 17'(r_in.x_right);
    assign cl17  = $signed({3'b000, r_clip_left});
    assign cr17  = $signed({3'b000, r_clip_right});
    assign ct17  = $signed({3'b000, r_clip_top});
    assign cb17  = $signed({3'b000, r_clip_bottom});
    assign xl_c  = (xl17 < cl17) ? cl17 : xl17;
    assign xr_c  = (xr17 > cr17) ? cr17 : xr17;
    assign rd_ok = 32'(r_in.read_index) < 32'(FRAME_WORDS);

    assign outside = r_loff[31] || r_roff[31]
                  || (32'(r_roff[31:3]) >= 32'(FRAME_WORDS))
                  || (r_loff[31:3] > r_roff[31:3]);

    assign out_free = !r_ovalid || !i_out_stall;

    assign keep = ((r_wa == r_lw) ? r_ml : 32'd0) | ((r_wa == r_rw) ? r_mr : 32'd0);

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = (ram_rdata & keep) | (r_in.pattern & ~keep);
        ram_raddr = r_w;
        if (r_wv) begin
            ram_we = 1'b1;
        end
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == AW'(FRAME_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                ram_raddr = AW'(r_in.read_index);
                if (r_in.req_type == REQ_READ && rd_ok) begin
                    n_state = S_RDWAIT;
                end else if ((r_in.req_type == REQ_FILL_CLIP
                              || r_in.req_type == REQ_FILL_NOCLIP)
                             && !(xr17 < xl17)) begin
                    if (r_in.req_type == REQ_FILL_NOCLIP) begin
                        n_state = S_ADDR;
                    end else if (row17 < ct17 || row17 > cb17
                                 || xr17 < cl17 || xl17 > cr17
                                 || xr_c < xl_c) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_ADDR;
                    end
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_ADDR: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = outside ? S_DRAIN : S_FILL;
            end
            S_FILL: begin
                if (r_w == r_rw) begin
                    n_state = S_DRAIN;
                end
            end
            S_RDWAIT: begin
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_wv && out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr         <= '0;
            r_wv          <= 1'b0;
            r_ovalid      <= 1'b0;
            r_row_width   <= 15'd128;
            r_clip_left   <= 14'd0;
            r_clip_right  <= 14'd127;
            r_clip_top    <= 14'd0;
            r_clip_bottom <= 14'd127;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ROW_WIDTH:   r_row_width   <= i_cfg_data;
                    CFG_CLIP_LEFT:   r_clip_left   <= i_cfg_data[13:0];
                    CFG_CLIP_RIGHT:  r_clip_right  <= i_cfg_data[13:0];
                    CFG_CLIP_TOP:    r_clip_top    <= i_cfg_data[13:0];
                    CFG_CLIP_BOTTOM: r_clip_bottom <= i_cfg_data[13:0];
                    default: ;
                endcase
            end

            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            r_wv <= (r_state == S_FILL);
            if (r_state == S_FILL) begin
                r_wa <= r_w;
                r_w  <= r_w + 1'b1;
            end

            if (r_state == S_DRAIN && !r_wv && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in   <= i_in;
                        r_data <= '0;
                        r_st   <= ST_DONE;
                    end
                end
                S_SETUP: begin
                    r_base <= r_in.row * $signed({1'b0, r_row_width});
                    if (r_in.req_type == REQ_READ) begin
                        if (!rd_ok) begin
                            r_st <= ST_OUTSIDE;
                        end
                    end else if (r_in.req_type == REQ_FILL_CLIP
                                 || r_in.req_type == REQ_FILL_NOCLIP) begin
                        if (xr17 < xl17) begin
                            r_st <= ST_REVERSED;
                        end else if (r_in.req_type == REQ_FILL_NOCLIP) begin
                            r_xl <= xl17;
                            r_xr <= xr17;
                        end else if (row17 < ct17 || row17 > cb17
                                     || xr17 < cl17 || xl17 > cr17
                                     || xr_c < xl_c) begin
                            r_st <= ST_CLIPPED;
                        end else begin
                            r_xl <= xl_c;
                            r_xr <= xr_c;
                        end
                    end
                end
                S_ADDR: begin
                    r_loff <= r_base + 32'(r_xl);
                    r_roff <= r_base + 32'(r_xr);
                end
                S_CHECK: begin
                    r_lw <= AW'(r_loff[31:3]);
                    r_rw <= AW'(r_roff[31:3]);
                    r_w  <= AW'(r_loff[31:3]);
                    r_ml <= keep_low(r_loff[2:0]);
                    r_mr <= keep_high(r_roff[2:0]);
                    if (outside) begin
                        r_st <= ST_OUTSIDE;
                    end
                end
                S_RDWAIT: begin
                    r_data <= ram_rdata;
                end
                S_DRAIN: begin
                    if (!r_wv && out_free) begin
                        r_out.read_data <= r_data;
                        r_out.status    <= r_st;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: tb/sv/pnsf_span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnsf_span_checker
// Watches the request, result and register channels of the span fill core.
// It keeps its own image of the framebuffer and of the clip window, works out
// the result of each accepted request and compares every result beat, field
// by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pnsf_span_checker
    import pnsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    logic [31:0] frame_img [FRAME_WORDS];
    longint      row_width;
    longint      win_left;
    longint      win_right;
    longint      win_top;
    longint      win_bottom;
    t_out        due_results [$];
    t_out        oldest;
    int          errors;
    int          checked;

    initial begin
        errors    = 0;
        checked   = 0;
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    task automatic flag_mismatch(input string msg);
        $display("[%0t] span checker: %s", $realtime, msg);
        errors++;
    endtask

    function automatic t_status paint_span(longint row, longint xl, longint xr,
                                           logic [31:0] pat);
        longint      base;
        longint      loff;
        longint      roff;
        longint      lw;
        longint      rw;
        logic [31:0] keep_lo;
        logic [31:0] keep_hi;
        logic [31:0] keep;
        base = row * row_width;
        loff = base + xl;
        roff = base + xr;
        if (loff < 0 || roff < 0) begin
            return ST_OUTSIDE;
        end
        lw = loff >>> 3;
        rw = roff >>> 3;
        if (rw >= FRAME_WORDS || lw > rw) begin
            return ST_OUTSIDE;
        end
        keep_lo = 32'((64'd1 << (4 * int'(loff & 7))) - 64'd1);
        keep_hi = 32'(~((64'd1 << (4 * (int'(roff & 7) + 1))) - 64'd1));
        for (longint w = lw; w <= rw; w++) begin
            keep = '0;
            if (w == lw) begin
                keep |= keep_lo;
            end
            if (w == rw) begin
                keep |= keep_hi;
            end
            frame_img[w] = (frame_img[w] & keep) | (pat & ~keep);
        end
        return ST_DONE;
    endfunction

    function automatic t_out predict_request(t_in req);
        t_out   r;
        longint row;
        longint xl;
        longint xr;
        row = longint'($signed(req.row));
        xl  = longint'($signed(req.x_left));
        xr  = longint'($signed(req.x_right));
        r.read_data = '0;
        r.status    = ST_DONE;
        case (req.req_type)
            REQ_READ: begin
                if (int'(req.read_index) < FRAME_WORDS) begin
                    r.read_data = frame_img[req.read_index];
                end else begin
                    r.status = ST_OUTSIDE;
                end
            end
            REQ_FILL_CLIP: begin
                if (xr < xl) begin
                    r.status = ST_REVERSED;
                end else if (row < win_top || row > win_bottom ||
                             xr < win_left || xl > win_right) begin
                    r.status = ST_CLIPPED;
                end else begin
                    if (xl < win_left) begin
                        xl = win_left;
                    end
                    if (xr > win_right) begin
                        xr = win_right;
                    end
                    if (xr < xl) begin
                        r.status = ST_CLIPPED;
                    end else begin
                        r.status = paint_span(row, xl, xr, req.pattern);
                    end
                end
            end
            REQ_FILL_NOCLIP: begin
                if (xr < xl) begin
                    r.status = ST_REVERSED;
                end else begin
                    r.status = paint_span(row, xl, xr, req.pattern);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < FRAME_WORDS; w++) begin
                frame_img[w] = '0;
            end
            row_width  = 128;
            win_left   = 0;
            win_right  = 127;
            win_top    = 0;
            win_bottom = 127;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROW_WIDTH:   row_width  = longint'(i_cfg_data);
                    CFG_CLIP_LEFT:   win_left   = longint'(i_cfg_data[13:0]);
                    CFG_CLIP_RIGHT:  win_right  = longint'(i_cfg_data[13:0]);
                    CFG_CLIP_TOP:    win_top    = longint'(i_cfg_data[13:0]);
                    CFG_CLIP_BOTTOM: win_bottom = longint'(i_cfg_data[13:0]);
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                due_results.push_back(predict_request(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    flag_mismatch($sformatf("result beat with nothing outstanding: %h",
                                            i_out));
                end else begin
                    oldest = due_results.pop_front();
                    if (i_out.read_data !== oldest.read_data) begin
                        flag_mismatch($sformatf("read_data got %h want %h",
                                                i_out.read_data, oldest.read_data));
                    end
                    if (i_out.status !== oldest.status) begin
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                i_out.status, oldest.status));
                    end
                    checked++;
                end
            end
        end
        o_pending <= due_results.size();
        o_errors  <= errors;
        o_checked <= checked;
    end

endmodule

FILE: tb/sv/tb_packed_nibble_span_fill_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_nibble_span_fill_core
// Regression for the packed nibble span fill core. A directed opening covers
// clipping, reversed spans, memory bounds and reads; then clip windows and
// row widths are loaded, each followed by random requests of all types and,
// save the last, idle and stall bursts. A side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_packed_nibble_span_fill_core;
    import pnsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_WINDOWS    = 7;
    localparam int PER_WINDOW     = 185;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [14:0] i_cfg_data;

    int          n_errors;
    int          n_pending;
    int          n_checked;
    logic        idle_en;
    int          stall_left;
    int          quiet_cycles;
    int          n_reads;
    int          n_clip_fills;
    int          n_plain_fills;
    int          n_other;
    longint      cur_rw;
    longint      cur_cl;
    longint      cur_cr;
    longint      cur_ct;
    longint      cur_cb;
    int          last_word;

    int win_rw [NUM_WINDOWS] = '{128, 1, 16384, 0, 64, 256, 128};
    int win_cl [NUM_WINDOWS] = '{8, 0, 0, 50, 16383, 3, 0};
    int win_cr [NUM_WINDOWS] = '{100, 16383, 16383, 40, 16383, 200, 127};
    int win_ct [NUM_WINDOWS] = '{2, 0, 0, 0, 16383, 0, 0};
    int win_cb [NUM_WINDOWS] = '{120, 16383, 0, 16383, 16383, 63, 127};

    packed_nibble_span_fill_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pnsf_span_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (n_errors),
        .o_pending   (n_pending),
        .o_checked   (n_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!idle_en) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(1, 10) - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("packed_nibble_span_fill_core regression: fail");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    function automatic t_in make_req(t_req kind, int row, int xl, int xr,
                                     logic [31:0] pat, int idx);
        t_in r;
        r.req_type   = kind;
        r.row        = 16'(row);
        r.x_left     = 16'(xl);
        r.x_right    = 16'(xr);
        r.pattern    = pat;
        r.read_index = 11'(idx);
        return r;
    endfunction

    function automatic t_in random_req();
        t_in         r;
        logic [95:0] raw;
        int          sel;
        longint      rh;
        longint      xh;
        longint      row;
        longint      xl;
        longint      len;
        longint      off;
        sel = $urandom_range(0, 99);
        if (sel >= 95) begin
            raw = {$urandom, $urandom, $urandom};
            return raw[92:0];
        end
        rh = (cur_rw == 0) ? 40 : 16384 / cur_rw;
        xh = (cur_rw > cur_cr + 2) ? cur_rw : cur_cr + 2;
        if (xh > 16383) begin
            xh = 16383;
        end
        case ($urandom_range(0, 19) / 3)
            0, 1, 2, 3: row = $urandom_range(0, int'(rh));
            4:          row = ($urandom_range(0, 1) ? cur_ct : cur_cb)
                              + $urandom_range(0, 2) - 1;
            default:    row = longint'($signed(16'($urandom)));
        endcase
        case ($urandom_range(0, 19) / 3)
            0, 1, 2, 3: xl = $urandom_range(0, int'(xh));
            4:          xl = ($urandom_range(0, 1) ? cur_cl : cur_cr)
                             + $urandom_range(0, 4) - 2;
            default:    xl = longint'($signed(16'($urandom)));
        endcase
        len = $urandom_range(0, 99);
        if (len < 85) begin
            len = $urandom_range(0, 40);
        end else if (len < 95) begin
            len = $urandom_range(0, 300);
        end else if (len < 97) begin
            len = $urandom_range(0, 17000);
        end else begin
            len = -longint'($urandom_range(1, 20));
        end
        if (sel < 30) begin
            r = make_req(REQ_READ, 0, 0, 0, $urandom,
                         $urandom_range(0, 1) ? int'($urandom)
                                              : last_word + $urandom_range(0, 3));
        end else if (sel < 90) begin
            r = make_req((sel < 60) ? REQ_FILL_CLIP : REQ_FILL_NOCLIP, int'(row), int'(xl),
                         int'(xl + len), $urandom, $urandom);
            off = row * cur_rw + xl;
            if (off >= 0) begin
                last_word = int'((off >>> 3) & 2047);
            end
        end else begin
            raw = {$urandom, $urandom, $urandom};
            r = raw[92:0];
            r.req_type = REQ_NONE;
        end
        return r;
    endfunction

    task automatic send(input t_in req);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        case (req.req_type)
            REQ_READ:        n_reads++;
            REQ_FILL_CLIP:   n_clip_fills++;
            REQ_FILL_NOCLIP: n_plain_fills++;
            default:         n_other++;
        endcase
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // hold off new requests until every outstanding result has drained
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (n_pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 15'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_window(input int w);
        wait_idle();
        cfg_write(CFG_ROW_WIDTH, win_rw[w]);
        cfg_write(CFG_CLIP_LEFT, win_cl[w]);
        cfg_write(CFG_CLIP_RIGHT, win_cr[w]);
        cfg_write(CFG_CLIP_TOP, win_ct[w]);
        cfg_write(CFG_CLIP_BOTTOM, win_cb[w]);
        i_cfg_valid <= 1'b0;
        cur_rw = win_rw[w];
        cur_cl = win_cl[w];
        cur_cr = win_cr[w];
        cur_ct = win_ct[w];
        cur_cb = win_cb[w];
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_ROW_WIDTH;
        i_cfg_data    = '0;
        idle_en       = 1'b0;
        stall_left    = 0;
        quiet_cycles  = 0;
        n_reads       = 0;
        n_clip_fills  = 0;
        n_plain_fills = 0;
        n_other       = 0;
        last_word     = 0;
        cur_rw        = 128;
        cur_cl        = 0;
        cur_cr        = 127;
        cur_ct        = 0;
        cur_cb        = 127;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_en <= 1'b1;

        send(make_req(REQ_READ, 0, 0, 0, 32'h0, 0));
        send(make_req(REQ_FILL_NOCLIP, 0, 0, 7, 32'h7654_3210, 0));
        send(make_req(REQ_READ, 0, 0, 0, 32'h0, 0));
        send(make_req(REQ_FILL_CLIP, 1, 3, 12, 32'hFEDC_BA98, 0));
        send(make_req(REQ_READ, 0, 0, 0, 32'h0, 16));
        send(make_req(REQ_READ, 0, 0, 0, 32'h0, 17));
        send(make_req(REQ_FILL_CLIP, 3, 5, 4, 32'h1111_1111, 0));
        send(make_req(REQ_FILL_NOCLIP, 3, 32767, -32768, 32'h2222_2222, 0));
        send(make_req(REQ_FILL_CLIP, -1, 0, 10, 32'h3333_3333, 0));
        send(make_req(REQ_FILL_CLIP, 128, 0, 10, 32'h4444_4444, 0));
        send(make_req(REQ_FILL_CLIP, 4, -10, -1, 32'h5555_5555, 0));
        send(make_req(REQ_FILL_CLIP, 4, 200, 300, 32'h6666_6666, 0));
        send(make_req(REQ_FILL_CLIP, 2, -32768, 32767, 32'hA5A5_A5A5, 0));
        send(make_req(REQ_READ, 0, 0, 0, 32'h0, 47));
        send(make_req(REQ_FILL_NOCLIP, -32768, 0, 0, 32'h7777_7777, 0));
        send(make_req(REQ_FILL_NOCLIP, 32767, 0, 0, 32'h8888_8888, 0));
        send(make_req(REQ_FILL_NOCLIP, 127, 120, 127, 32'hC3C3_C3C3, 0));
        send(make_req(REQ_READ, 0, 0, 0, 32'h0, 2047));
        send(make_req(REQ_FILL_NOCLIP, 0, -1, 3, 32'h9999_9999, 0));
        send(make_req(REQ_FILL_NOCLIP, 127, 0, 128, 32'hAAAA_AAAA, 0));
        send(make_req(REQ_NONE, -1, -1, -1, 32'hFFFF_FFFF, 2047));
        send(make_req(REQ_READ, 0, 0, 0, 32'h0, 1024));
        send(make_req(REQ_FILL_NOCLIP, 0, 4, 4, 32'hFFFF_FFFF, 0));
        send(make_req(REQ_READ, 0, 0, 0, 32'h0, 0));

        for (int w = 0; w < NUM_WINDOWS; w++) begin
            load_window(w);
            for (int k = 0; k < PER_WINDOW; k++) begin
                if (k % 40 == 0) begin
                    idle_en <= (w == NUM_WINDOWS - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 199) == 0) begin
                    wait_idle();
                end
                send(random_req());
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (n_pending != 0);
        repeat (30) @(posedge i_clk);

        $display("covered %0d reads, %0d clipped fills, %0d unclipped fills, %0d others",
                 n_reads, n_clip_fills, n_plain_fills, n_other);
        $display("over %0d clip windows; %0d results checked, %0d mismatches",
                 NUM_WINDOWS + 1, n_checked, n_errors);
        if (n_errors == 0) begin
            $display("packed_nibble_span_fill_core regression: pass");
        end else begin
            $display("packed_nibble_span_fill_core regression: fail");
        end
        $finish;
    end

endmodule
